### sv/owm_pkg.sv
package owm_pkg;

  localparam int CNT_W = 10;
  localparam int CFG_W = 10;
  localparam int REG_NUM = 8;
  localparam int IDX_W = $clog2(REG_NUM);
  localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_RESET_LOW     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RESET_RELEASE = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_PRES_WAIT     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PRES_END      = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_SHORT_SLOT    = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_LONG_SLOT     = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_SAMPLE_DELAY  = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_READ_RECOVERY = IDX_W'(7);

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] reset_release_ticks;
    logic [9:0] presence_wait_limit;
    logic [9:0] presence_end_limit;
    logic [3:0] short_slot_ticks;
    logic [7:0] long_slot_ticks;
    logic [5:0] sample_delay_ticks;
    logic [7:0] read_recovery_ticks;
  } cfg_regs_t;

  function automatic logic [CNT_W-1:0] limit_of(input logic [CFG_W-1:0] t);
    logic [CMP_W-1:0] tw;
    logic [CMP_W-1:0] mw;
    tw = CMP_W'(t);
    mw = CMP_W'(CNT_MAX);
    if (t == '0) begin
      limit_of = CNT_W'(1);
    end else if (tw > mw) begin
      limit_of = CNT_MAX;
    end else begin
      limit_of = CNT_W'(tw);
    end
  endfunction

endpackage

### sv/owm_if.sv
interface owm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       line_in;

  modport source (output valid, output mode, output data_byte, output line_in, input ready);
  modport sink (input valid, input mode, input data_byte, input line_in, output ready);
endinterface

interface owm_out_if;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic [1:0] status;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output read_data, output status, input ready);
  modport sink (input valid, input drive_low, input busy_res, input done_res,
                input read_data, input status, output ready);
endinterface

### sv/owm_cfg.sv
module owm_cfg
  import owm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_regs_t        regs
);

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low_ticks     <= 10'd750;
      regs_r.reset_release_ticks <= 8'd15;
      regs_r.presence_wait_limit <= 10'd200;
      regs_r.presence_end_limit  <= 10'd240;
      regs_r.short_slot_ticks    <= 4'd2;
      regs_r.long_slot_ticks     <= 8'd60;
      regs_r.sample_delay_ticks  <= 6'd12;
      regs_r.read_recovery_ticks <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:     regs_r.reset_low_ticks     <= cfg_data[9:0];
        REG_RESET_RELEASE: regs_r.reset_release_ticks <= cfg_data[7:0];
        REG_PRES_WAIT:     regs_r.presence_wait_limit <= cfg_data[9:0];
        REG_PRES_END:      regs_r.presence_end_limit  <= cfg_data[9:0];
        REG_SHORT_SLOT:    regs_r.short_slot_ticks    <= cfg_data[3:0];
        REG_LONG_SLOT:     regs_r.long_slot_ticks     <= cfg_data[7:0];
        REG_SAMPLE_DELAY:  regs_r.sample_delay_ticks  <= cfg_data[5:0];
        REG_READ_RECOVERY: regs_r.read_recovery_ticks <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign regs = regs_r;

endmodule

### sv/one_wire_bus_master_top.sv
// One word in, one word out: each accepted tick word yields its result word in the output register on the next cycle.
// Throughput is one word per cycle unless the output stalls; the bus state advances in a single registered pass.
// A full output register still accepts a new word in the cycle it is taken downstream.
// Synchronous active-low reset returns to idle, clears status and read data, and loads
// the default timing registers.
module one_wire_bus_master_top
  import owm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  owm_in_if.sink           in_word,
  owm_out_if.source        out_word,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_RST_LOW   = 4'd1;
  localparam logic [3:0] PH_RST_REL   = 4'd2;
  localparam logic [3:0] PH_PRES_WAIT = 4'd3;
  localparam logic [3:0] PH_PRES_END  = 4'd4;
  localparam logic [3:0] PH_WR_LOW    = 4'd5;
  localparam logic [3:0] PH_WR_REL    = 4'd6;
  localparam logic [3:0] PH_RD_LOW    = 4'd7;
  localparam logic [3:0] PH_RD_WAIT   = 4'd8;
  localparam logic [3:0] PH_RD_REC    = 4'd9;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PRES = 2'd1;
  localparam logic [1:0] ST_STUCK   = 2'd2;

  cfg_regs_t regs;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  logic [3:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [3:0]       bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [7:0]       rdata_r, rdata_nxt;

  logic       out_valid_r;
  logic       drive_r, busy_r, done_r;
  logic       drive_nxt, busy_nxt, done_nxt;
  logic       accept;

  logic [3:0]       ph;
  logic [7:0]       shift_in;
  logic [3:0]       bit_in;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W-1:0] cnt_inc;
  logic [CFG_W-1:0] target;
  logic             t_end;
  logic             fin;
  logic [3:0]       bc_inc;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept = in_word.valid && in_word.ready;

  always_comb begin
    ph = phase_r;
    shift_in = shift_r;
    cnt_base = tick_r;
    bit_in = bit_r;
    if (phase_r == PH_IDLE) begin
      cnt_base = '0;
      bit_in = '0;
      case (in_word.mode)
        MODE_RESET: ph = PH_RST_LOW;
        MODE_WRITE: begin
          ph = PH_WR_LOW;
          shift_in = in_word.data_byte;
        end
        MODE_READ: begin
          ph = PH_RD_LOW;
          shift_in = '0;
        end
        default: ph = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    case (ph)
      PH_RST_LOW:   target = CFG_W'(regs.reset_low_ticks);
      PH_RST_REL:   target = CFG_W'(regs.reset_release_ticks);
      PH_PRES_WAIT: target = CFG_W'(regs.presence_wait_limit);
      PH_PRES_END:  target = CFG_W'(regs.presence_end_limit);
      PH_WR_LOW:    target = shift_in[0] ? CFG_W'(regs.short_slot_ticks)
                                         : CFG_W'(regs.long_slot_ticks);
      PH_WR_REL:    target = shift_in[0] ? CFG_W'(regs.long_slot_ticks)
                                         : CFG_W'(regs.short_slot_ticks);
      PH_RD_LOW:    target = CFG_W'(regs.short_slot_ticks);
      PH_RD_WAIT:   target = CFG_W'(regs.sample_delay_ticks);
      PH_RD_REC:    target = CFG_W'(regs.read_recovery_ticks);
      default:      target = CFG_W'(1);
    endcase
    cnt_inc = (cnt_base < CNT_MAX) ? cnt_base + CNT_W'(1) : CNT_MAX;
    t_end = cnt_inc >= limit_of(target);
  end

  always_comb begin
    phase_nxt = ph;
    tick_nxt = cnt_base;
    shift_nxt = shift_in;
    bit_nxt = bit_in;
    status_nxt = status_r;
    rdata_nxt = rdata_r;
    drive_nxt = 1'b0;
    busy_nxt = 1'b1;
    done_nxt = 1'b0;
    fin = 1'b0;
    bc_inc = bit_in + 4'd1;
    case (ph)
      PH_RST_LOW: begin
        drive_nxt = 1'b1;
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          phase_nxt = PH_RST_REL;
        end
      end
      PH_RST_REL: begin
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          phase_nxt = PH_PRES_WAIT;
        end
      end
      PH_PRES_WAIT: begin
        if (!in_word.line_in) begin
          phase_nxt = PH_PRES_END;
          tick_nxt = CNT_W'(1);
          if (limit_of(CFG_W'(regs.presence_end_limit)) == CNT_W'(1)) begin
            status_nxt = ST_STUCK;
            fin = 1'b1;
          end
        end else begin
          tick_nxt = t_end ? '0 : cnt_inc;
          if (t_end) begin
            status_nxt = ST_NO_PRES;
            fin = 1'b1;
          end
        end
      end
      PH_PRES_END: begin
        if (in_word.line_in) begin
          status_nxt = ST_OK;
          fin = 1'b1;
        end else begin
          tick_nxt = t_end ? '0 : cnt_inc;
          if (t_end) begin
            status_nxt = ST_STUCK;
            fin = 1'b1;
          end
        end
      end
      PH_WR_LOW: begin
        drive_nxt = 1'b1;
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          phase_nxt = PH_WR_REL;
        end
      end
      PH_WR_REL: begin
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          shift_nxt = {1'b0, shift_in[7:1]};
          bit_nxt = bc_inc;
          if (bc_inc >= 4'd8) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_WR_LOW;
          end
        end
      end
      PH_RD_LOW: begin
        drive_nxt = 1'b1;
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          phase_nxt = PH_RD_WAIT;
        end
      end
      PH_RD_WAIT: begin
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          shift_nxt = {in_word.line_in, shift_in[7:1]};
          phase_nxt = PH_RD_REC;
        end
      end
      PH_RD_REC: begin
        tick_nxt = t_end ? '0 : cnt_inc;
        if (t_end) begin
          bit_nxt = bc_inc;
          if (bc_inc >= 4'd8) begin
            rdata_nxt = shift_in;
            fin = 1'b1;
          end else begin
            phase_nxt = PH_RD_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        busy_nxt = 1'b0;
      end
    endcase
    if (fin) begin
      phase_nxt = PH_IDLE;
      tick_nxt = '0;
      bit_nxt = '0;
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r <= '0;
      bit_r <= '0;
      shift_r <= '0;
      status_r <= ST_OK;
      rdata_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        tick_r <= tick_nxt;
        bit_r <= bit_nxt;
        shift_r <= shift_nxt;
        status_r <= status_nxt;
        rdata_r <= rdata_nxt;
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r <= drive_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_word.valid = out_valid_r;
  assign out_word.drive_low = drive_r;
  assign out_word.busy_res = busy_r;
  assign out_word.done_res = done_r;
  assign out_word.read_data = rdata_r;
  assign out_word.status = status_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && done_r |-> !busy_r)
    else $error("done word reports busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_nxt |=> phase_r == PH_IDLE && bit_r == 4'd0 && tick_r == '0)
    else $error("sequencer not idle after command completion");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    status_r <= ST_STUCK)
    else $error("illegal status code");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r < 4'd8)
    else $error("bit count past one byte");

  a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(phase_r) && $stable(tick_r) && $stable(shift_r))
    else $error("sequencer state moved without an accepted word");

endmodule
